### rtl/crs_pkg.sv
// Shared widths and constants for the curvature run segmenter.
`timescale 1ns / 1ps

package crs_pkg;

   localparam int CURV_W     = 16;
   localparam int MAG_W      = CURV_W + 1;
   localparam int THR_W      = 15;
   localparam int IDX_W      = 12;
   localparam int COUNT_W    = 12;
   localparam int SUM_W      = 32;

   // 0.185 in Q3.12
   localparam logic [THR_W-1:0]   THR_RESET = 15'd758;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

   typedef logic signed [CURV_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]         index_type;

endpackage

### rtl/crs_channels.sv
// Valid/ready channel interfaces for requests, results and the threshold register.
`timescale 1ns / 1ps

interface crs_req_if;
   import crs_pkg::*;

   logic       valid;
   logic       ready;
   sample_type curvature;
   logic       end_of_line;

   modport source (output valid, output curvature, output end_of_line, input ready);
   modport sink   (input valid, input curvature, input end_of_line, output ready);
endinterface

interface crs_rsp_if;
   import crs_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] run_number;
   index_type          start_index;
   index_type          end_index;
   sample_type         peak_value;
   index_type          peak_index;
   sample_type         min_value;
   sample_type         max_value;
   logic [SUM_W-1:0]   sum_value;
   logic               line_done;

   modport source (output valid, output run_number, output start_index, output end_index,
                   output peak_value, output peak_index, output min_value, output max_value,
                   output sum_value, output line_done, input ready);
   modport sink   (input valid, input run_number, input start_index, input end_index,
                   input peak_value, input peak_index, input min_value, input max_value,
                   input sum_value, input line_done, output ready);
endinterface

interface crs_csr_if;
   import crs_pkg::*;

   logic             valid;
   logic             ready;
   logic [THR_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/curvature_run_segmenter.sv
// A request waits in the input register; the run-state update writes any result
// to the result register. Throughput: one request per cycle while that register
// is free or draining, set by the single-stage run-state update between them.
// A pending result does not stall intake until the input register is also full.
// Reset (synchronous, active high) clears the run state, empties both registers
// and loads the threshold with 758 (0.185 in Q3.12).
`timescale 1ns / 1ps

module curvature_run_segmenter #(
   parameter int INDEX_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   crs_req_if.sink          req_if,
   crs_rsp_if.source        rsp_if,
   crs_csr_if.sink          csr_if
);
   import crs_pkg::*;

   localparam int IDX_EXT_W = (INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

   // Input register
   logic                  in_valid_ff, in_valid_in;
   sample_type            in_curv_ff;
   logic                  in_eol_ff;

   // Threshold register
   logic [THR_W-1:0]      thr_ff;

   // Run state
   logic [INDEX_BITS-1:0] position_ff, position_in;
   logic                  in_run_ff, in_run_in;
   logic [COUNT_W-1:0]    run_count_ff, run_count_in;
   index_type             run_start_ff, run_start_in;
   index_type             run_end_ff, run_end_in;
   sample_type            run_peak_ff, run_peak_in;
   index_type             run_peak_at_ff, run_peak_at_in;
   sample_type            run_min_ff, run_min_in;
   sample_type            run_max_ff, run_max_in;
   logic [SUM_W-1:0]      run_sum_ff, run_sum_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    rsp_number_ff;
   index_type             rsp_start_ff;
   index_type             rsp_end_ff;
   sample_type            rsp_peak_ff;
   index_type             rsp_peak_at_ff;
   sample_type            rsp_min_ff;
   sample_type            rsp_max_ff;
   logic [SUM_W-1:0]      rsp_sum_ff;
   logic                  rsp_done_ff;

   logic                  advance;
   logic                  emit;
   logic                  emit_done;
   logic [IDX_EXT_W-1:0]  idx_ext;
   index_type             idx;
   logic [MAG_W-1:0]      curv_mag;
   logic [MAG_W-1:0]      peak_mag;
   logic                  over;

   function automatic logic [MAG_W-1:0] magnitude(input sample_type v);
      logic signed [MAG_W-1:0] wide;
      wide = MAG_W'(v);
      return wide[MAG_W-1] ? MAG_W'(-wide) : MAG_W'(wide);
   endfunction

   // The stage moves when the result register is free or is being drained.
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign csr_if.ready  = 1'b1;

   assign idx_ext  = IDX_EXT_W'(position_ff);
   assign idx      = idx_ext[IDX_W-1:0];
   assign curv_mag = magnitude(in_curv_ff);
   assign peak_mag = magnitude(run_peak_ff);
   assign over     = curv_mag > MAG_W'(thr_ff);

   always_comb begin
      in_valid_in    = in_valid_ff;
      position_in    = position_ff;
      in_run_in      = in_run_ff;
      run_count_in   = run_count_ff;
      run_start_in   = run_start_ff;
      run_end_in     = run_end_ff;
      run_peak_in    = run_peak_ff;
      run_peak_at_in = run_peak_at_ff;
      run_min_in     = run_min_ff;
      run_max_in     = run_max_ff;
      run_sum_in     = run_sum_ff;
      emit           = 1'b0;
      emit_done      = 1'b0;

      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance) begin
         if (in_eol_ff) begin
            // The final sample is not examined; it closes an open run and resets the position and run count.
            emit         = in_run_ff;
            emit_done    = 1'b1;
            position_in  = '0;
            in_run_in    = 1'b0;
            run_count_in = '0;
         end else begin
            if (position_ff != INDEX_MAX) begin
               position_in = position_ff + 1'b1;
            end
            if (position_ff != '0) begin
               if (over) begin
                  if (in_run_ff) begin
                     emit      = 1'b1;
                     in_run_in = 1'b0;
                     if (run_count_ff != COUNT_MAX) begin
                        run_count_in = run_count_ff + 1'b1;
                     end
                  end
               end else if (!in_run_ff) begin
                  in_run_in      = 1'b1;
                  run_start_in   = idx;
                  run_end_in     = idx;
                  run_peak_in    = in_curv_ff;
                  run_peak_at_in = idx;
                  run_min_in     = in_curv_ff;
                  run_max_in     = in_curv_ff;
                  run_sum_in     = '0;
               end else begin
                  run_end_in = idx;
                  // A tie keeps the earlier peak.
                  if (peak_mag < curv_mag) begin
                     run_peak_in    = in_curv_ff;
                     run_peak_at_in = idx;
                  end
                  if (in_curv_ff < run_min_ff) begin
                     run_min_in = in_curv_ff;
                  end else if (in_curv_ff > run_max_ff) begin
                     run_max_in = in_curv_ff;
                  end
                  run_sum_in = run_sum_ff + SUM_W'(in_curv_ff);
               end
            end
         end
      end

      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         thr_ff       <= THR_RESET;
         position_ff  <= '0;
         in_run_ff    <= 1'b0;
         run_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         position_ff  <= position_in;
         in_run_ff    <= in_run_in;
         run_count_ff <= run_count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            thr_ff <= csr_if.data;
         end
      end

      if (req_if.valid && req_if.ready) begin
         in_curv_ff <= req_if.curvature;
         in_eol_ff  <= req_if.end_of_line;
      end

      run_start_ff   <= run_start_in;
      run_end_ff     <= run_end_in;
      run_peak_ff    <= run_peak_in;
      run_peak_at_ff <= run_peak_at_in;
      run_min_ff     <= run_min_in;
      run_max_ff     <= run_max_in;
      run_sum_ff     <= run_sum_in;

      if (advance && emit) begin
         rsp_number_ff  <= run_count_ff;
         rsp_start_ff   <= run_start_ff;
         rsp_end_ff     <= run_end_ff;
         rsp_peak_ff    <= run_peak_ff;
         rsp_peak_at_ff <= run_peak_at_ff;
         rsp_min_ff     <= run_min_ff;
         rsp_max_ff     <= run_max_ff;
         rsp_sum_ff     <= run_sum_ff;
         rsp_done_ff    <= emit_done;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.run_number  = rsp_number_ff;
   assign rsp_if.start_index = rsp_start_ff;
   assign rsp_if.end_index   = rsp_end_ff;
   assign rsp_if.peak_value  = rsp_peak_ff;
   assign rsp_if.peak_index  = rsp_peak_at_ff;
   assign rsp_if.min_value   = rsp_min_ff;
   assign rsp_if.max_value   = rsp_max_ff;
   assign rsp_if.sum_value   = rsp_sum_ff;
   assign rsp_if.line_done   = rsp_done_ff;

`ifndef SYNTH
   // The end of a polyline leaves the block ready for the next one.
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_eol_ff |=> position_ff == '0 && !in_run_ff && run_count_ff == '0)
      else $error("polyline end did not clear the run state");

   // A new result only appears after a request moved through the stage.
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a processed request");

   // The peak has the largest magnitude of the run, so it bounds the extremes.
   a_peak_bounds: assert property (@(posedge clock) disable iff (reset)
      in_run_ff |-> peak_mag >= magnitude(run_min_ff) && peak_mag >= magnitude(run_max_ff))
      else $error("run peak smaller than a run extreme");
`endif

endmodule
